// ===== hw/rtl/ip_transport_checksum_macros.svh =====
// assertion macros for the ip transport checksum block
// no dependencies; taken in by the files that carry assertions
`ifndef IP_TRANSPORT_CHECKSUM_MACROS_SVH
`define IP_TRANSPORT_CHECKSUM_MACROS_SVH

`ifndef NO_ASSERTIONS
// clocked check, disabled while reset is low
`define IPCS_ASSERT_RST(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ipcs assertion failed");
// clocked check that also holds during reset
`define IPCS_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ipcs assertion failed");
`else
`define IPCS_ASSERT_RST(label, clk, rstn, prop)
`define IPCS_ASSERT(label, clk, prop)
`endif

`endif

// ===== hw/rtl/ipcs_pkg.sv =====
// shared types, constants and the ones-complement adder of the checksum block
// no dependencies
package ipcs_pkg;

  localparam int unsigned POSITION_WIDTH = 16;

  typedef logic [POSITION_WIDTH-1:0] pos_t;

  // top of the byte position counter
  localparam pos_t POS_TOP = {POSITION_WIDTH{1'b1}};

  // header field positions
  localparam pos_t POS_V4_TLEN_HI    = pos_t'(2);
  localparam pos_t POS_V4_TLEN_LO    = pos_t'(3);
  localparam pos_t POS_V4_PROTO      = pos_t'(9);
  localparam pos_t POS_V4_ADDR_FIRST = pos_t'(12);
  localparam pos_t POS_V4_ADDR_LAST  = pos_t'(19);
  localparam pos_t POS_V6_PLEN_HI    = pos_t'(4);
  localparam pos_t POS_V6_PLEN_LO    = pos_t'(5);
  localparam pos_t POS_V6_NEXT_HDR   = pos_t'(6);
  localparam pos_t POS_V6_ADDR_FIRST = pos_t'(8);

  localparam logic [3:0] VERSION_FOUR   = 4'h4;
  localparam logic [5:0] IP6_HDR_BYTES  = 6'd40;
  localparam logic [5:0] IP4_MIN_HDR    = 6'd20;

  // per-packet state
  typedef struct packed {
    pos_t        pos;
    logic [15:0] sum;
    logic [7:0]  high;
    logic        mode;
    logic        v4;
    logic [5:0]  hdr;
  } ipcs_state_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic        short_packet;
  } ipcs_result_t;

  // ones-complement add with end-around carry; stays within 16 bits
  function automatic logic [15:0] ipcs_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

// ===== hw/rtl/ipcs_intf.sv =====
// handshake channels of the checksum block: byte input and result output
// no dependencies
interface ipcs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  logic       mode;

  modport source (output valid, output data_byte, output last, output mode, input ready);
  modport sink   (input valid, input data_byte, input last, input mode, output ready);
endinterface

interface ipcs_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum;
  logic        short_packet;

  modport source (output valid, output checksum, output short_packet, input ready);
  modport sink   (input valid, input checksum, input short_packet, output ready);
endinterface

// ===== hw/rtl/ipcs_step.sv =====
// next-state and result logic for one packet byte
// depends on ipcs_pkg
module ipcs_step (
  input  ipcs_pkg::ipcs_state_t  state_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_i,
  input  logic                   mode_i,
  output ipcs_pkg::ipcs_state_t  state_o,
  output ipcs_pkg::ipcs_result_t result_o
);
  import ipcs_pkg::*;

  logic                  first;
  logic                  mode_eff;
  logic                  v4_eff;
  logic [5:0]            hdr_eff;
  pos_t                  pos;
  pos_t                  hdr_pos;
  logic [15:0]           lane;
  logic [15:0]           byte_word;
  logic [15:0]           len_word;
  logic [15:0]           word_a;
  logic [15:0]           word_b;
  logic [15:0]           sum_a;
  logic [15:0]           sum_b;
  logic [POSITION_WIDTH:0] count;
  logic                  is_short;

  // header facts come from the first byte itself on position zero
  always_comb begin
    pos      = state_i.pos;
    first    = (pos == '0);
    mode_eff = first ? mode_i : state_i.mode;
    v4_eff   = first ? (data_byte_i[7:4] == VERSION_FOUR) : state_i.v4;
    if (first) begin
      hdr_eff = v4_eff ? {data_byte_i[3:0], 2'b00} : IP6_HDR_BYTES;
    end else begin
      hdr_eff = state_i.hdr;
    end
    hdr_pos = pos_t'(hdr_eff);
  end

  // word views of the byte
  assign lane      = pos[0] ? {8'h00, data_byte_i} : {data_byte_i, 8'h00};
  assign byte_word = {8'h00, data_byte_i};
  assign len_word  = {state_i.high, data_byte_i} - {10'b0, hdr_eff};

  // select at most two words to add for this byte
  always_comb begin
    word_a = '0;
    word_b = '0;
    if (!mode_eff) begin
      word_a = lane;
    end else if (v4_eff) begin
      if (pos == POS_V4_TLEN_LO) begin
        word_a = len_word;
      end else if (pos == POS_V4_PROTO) begin
        word_a = byte_word;
      end else if (pos >= POS_V4_ADDR_FIRST && pos <= POS_V4_ADDR_LAST) begin
        word_a = lane;
      end
      if (pos >= hdr_pos) begin
        word_b = lane;
      end
    end else begin
      if (pos == POS_V6_PLEN_HI || pos == POS_V6_PLEN_LO) begin
        word_a = lane;
      end else if (pos == POS_V6_NEXT_HDR) begin
        word_a = byte_word;
      end
      if (pos >= POS_V6_ADDR_FIRST) begin
        word_b = lane;
      end
    end
  end

  assign sum_a = ipcs_add(state_i.sum, word_a);
  assign sum_b = ipcs_add(sum_a, word_b);

  // header completeness on the last byte
  always_comb begin
    count    = {1'b0, pos} + {{POSITION_WIDTH{1'b0}}, 1'b1};
    is_short = 1'b0;
    if (mode_eff) begin
      if (v4_eff) begin
        is_short = (count < (POSITION_WIDTH+1)'(IP4_MIN_HDR)) ||
                   (count < (POSITION_WIDTH+1)'(hdr_eff));
      end else begin
        is_short = (count < (POSITION_WIDTH+1)'(IP6_HDR_BYTES));
      end
    end
  end

  // next packet state
  always_comb begin
    state_o.mode = mode_eff;
    state_o.v4   = v4_eff;
    state_o.hdr  = hdr_eff;
    if (last_i) begin
      state_o.pos  = '0;
      state_o.sum  = '0;
      state_o.high = '0;
    end else begin
      state_o.pos  = (pos >= POS_TOP) ? (POS_TOP - pos_t'(1)) : (pos + pos_t'(1));
      state_o.sum  = sum_b;
      if (pos == POS_V4_TLEN_HI) begin
        state_o.high = data_byte_i;
      end else if (first) begin
        state_o.high = '0;
      end else begin
        state_o.high = state_i.high;
      end
    end
  end

  assign result_o.checksum     = ~sum_b;
  assign result_o.short_packet = is_short;

endmodule

// ===== hw/rtl/ipcs_out_stage.sv =====
// result register with valid flag, parts the result side from the byte side
// depends on ipcs_pkg
module ipcs_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  ipcs_pkg::ipcs_result_t result_i,
  input  logic                   ready_i,
  output logic                   valid_o,
  output ipcs_pkg::ipcs_result_t result_o
);
  import ipcs_pkg::*;

  logic         valid_q;
  ipcs_result_t result_q;

  // valid flag: set on load, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== hw/rtl/ip_transport_checksum.sv =====
// ip_transport_checksum: Internet checksum over an IP packet, one byte per item.
// depends on ipcs_pkg, ipcs_intf, ipcs_step, ipcs_out_stage and the macros header
//
// byte_i carries data_byte, last and mode; mode is taken on the first byte of a
// packet (0 plain checksum over all bytes, 1 transport checksum with the IPv4 or
// IPv6 pseudo-header). result_o gives one item per packet: the complemented
// folded sum in network order and, in transport mode, a flag for a packet that
// ended inside the IP header.
// Throughput: one byte per cycle while no waiting result stalls the input. The per-byte work is two 16-bit
// end-around-carry adds between the packet state register and the result
// register, and that adder chain sets the cycle.
// Latency: the result is valid in the cycle after the last byte is accepted.
// Reset clears the packet state and the result flag; the block takes bytes as
// soon as reset is released.
// When the receiver stalls, the result stays in its register; while a result
// waits and result_o.ready is low, byte_i.ready is low for every byte, so a
// stall at the result side holds the byte input as well.
`include "ip_transport_checksum_macros.svh"

module ip_transport_checksum (
  input logic          clk_i,
  input logic          rst_ni,
  ipcs_byte_if.sink    byte_i,
  ipcs_result_if.source result_o
);
  import ipcs_pkg::*;

  ipcs_state_t  state_q;
  ipcs_state_t  state_d;
  ipcs_result_t step_result;
  ipcs_result_t out_result;
  logic         out_valid;
  logic         in_acc;

  // input handshake
  assign byte_i.ready = !out_valid || result_o.ready;
  assign in_acc       = byte_i.valid && byte_i.ready;

  ipcs_step u_step (
    .state_i     (state_q),
    .data_byte_i (byte_i.data_byte),
    .last_i      (byte_i.last),
    .mode_i      (byte_i.mode),
    .state_o     (state_d),
    .result_o    (step_result)
  );

  // packet state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  ipcs_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_acc && byte_i.last),
    .result_i (step_result),
    .ready_i  (result_o.ready),
    .valid_o  (out_valid),
    .result_o (out_result)
  );

  assign result_o.valid        = out_valid;
  assign result_o.checksum     = out_result.checksum;
  assign result_o.short_packet = out_result.short_packet;

  // checks
  `IPCS_ASSERT_RST(a_last_loads_result, clk_i, rst_ni, (in_acc && byte_i.last) |=> out_valid)
  `IPCS_ASSERT_RST(a_last_clears_state, clk_i, rst_ni, (in_acc && byte_i.last) |=> (state_q.pos == '0 && state_q.sum == '0))
  `IPCS_ASSERT(a_stall_blocks_input, clk_i, (out_valid && !result_o.ready) |-> !byte_i.ready)

endmodule

// ===== test/tb.sv =====
// testbench for ip_transport_checksum: drives packets byte by byte and checks each result
// depends on ipcs_pkg, ipcs_intf and the ip_transport_checksum rtl
`timescale 1ns / 1ps

import ipcs_pkg::*;

// predicts the checksum of each packet and holds results still to arrive
class checksum_scoreboard;
  pos_t         pos;
  logic [15:0]  sum;
  logic [7:0]   tlen_high;
  logic [15:0]  tlen;
  logic         pkt_mode;
  logic         v4;
  logic [5:0]   hdr_len;
  ipcs_result_t expected_sums[$];
  int unsigned  mismatches;

  function new();
    pos        = '0;
    sum        = '0;
    tlen_high  = '0;
    tlen       = '0;
    pkt_mode   = 1'b0;
    v4         = 1'b0;
    hdr_len    = '0;
    mismatches = 0;
  endfunction

  // ones-complement add with end-around carry
  function void fold_in(logic [15:0] w);
    logic [16:0] s;
    s   = {1'b0, sum} + {1'b0, w};
    sum = s[15:0] + {15'b0, s[16]};
  endfunction

  // note one accepted input byte
  function void take_byte(logic [7:0] b, logic fin, logic m);
    logic [15:0]  lane;
    int unsigned  count;
    ipcs_result_t res;
    if (pos == '0) begin
      pkt_mode  = m;
      v4        = (b[7:4] == VERSION_FOUR);
      hdr_len   = v4 ? {b[3:0], 2'b00} : IP6_HDR_BYTES;
      tlen_high = '0;
      tlen      = '0;
    end
    lane = pos[0] ? {8'h00, b} : {b, 8'h00};

    if (!pkt_mode) begin
      fold_in(lane);
    end else if (v4) begin
      if (pos == POS_V4_TLEN_HI) tlen_high = b;
      if (pos == POS_V4_TLEN_LO) begin
        tlen = {tlen_high, b};
        fold_in(tlen - {10'b0, hdr_len});
      end
      if (pos == POS_V4_PROTO) fold_in({8'h00, b});
      if (pos >= POS_V4_ADDR_FIRST && pos <= POS_V4_ADDR_LAST) fold_in(lane);
      if (pos >= pos_t'(hdr_len)) fold_in(lane);
    end else begin
      if (pos == POS_V6_PLEN_HI || pos == POS_V6_PLEN_LO) fold_in(lane);
      if (pos == POS_V6_NEXT_HDR) fold_in({8'h00, b});
      if (pos >= POS_V6_ADDR_FIRST) fold_in(lane);
    end

    if (fin) begin
      count = int'(pos) + 1;
      res.checksum = ~sum;
      res.short_packet = 1'b0;
      if (pkt_mode) begin
        if (v4) res.short_packet = (count < int'(IP4_MIN_HDR)) || (count < int'(hdr_len));
        else    res.short_packet = (count < int'(IP6_HDR_BYTES));
      end
      expected_sums.push_back(res);
      pos       = '0;
      sum       = '0;
      tlen_high = '0;
      tlen      = '0;
    end else begin
      // counter saturates by toggling below its top so byte pairing holds
      pos = (pos == POS_TOP) ? POS_TOP - pos_t'(1) : pos + pos_t'(1);
    end
  endfunction

  // compare one accepted result with the oldest prediction
  function void check_result(logic [15:0] cs, logic sp);
    ipcs_result_t want;
    if (expected_sums.size() == 0) begin
      $display("%0t: unexpected result: checksum %h short_packet %b", $time, cs, sp);
      mismatches++;
      return;
    end
    want = expected_sums.pop_front();
    if (cs !== want.checksum) begin
      $display("%0t: checksum expected %h actual %h", $time, want.checksum, cs);
      mismatches++;
    end
    if (sp !== want.short_packet) begin
      $display("%0t: short_packet expected %b actual %b", $time, want.short_packet, sp);
      mismatches++;
    end
  endfunction
endclass

module tb;
  localparam int unsigned IDLE_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;

  ipcs_byte_if   byte_ch();
  ipcs_result_if res_ch();

  ip_transport_checksum u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_ch),
    .result_o (res_ch)
  );

  checksum_scoreboard sb = new();
  logic [7:0]         pkt_bytes[$];
  int unsigned        bytes_sent;
  int unsigned        packets_sent;

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // packet builders fill pkt_bytes
  function automatic void fill_random(int unsigned n);
    pkt_bytes.delete();
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endfunction

  function automatic void make_v4(logic [3:0] ihl, int unsigned n, logic [15:0] tlen_field);
    fill_random(n);
    if (n > 0) pkt_bytes[0] = {VERSION_FOUR, ihl};
    if (n > 2) pkt_bytes[2] = tlen_field[15:8];
    if (n > 3) pkt_bytes[3] = tlen_field[7:0];
  endfunction

  function automatic void make_v6(logic [3:0] ver, int unsigned n, logic [15:0] plen);
    fill_random(n);
    if (n > 0) pkt_bytes[0] = {ver, 4'($urandom)};
    if (n > 4) pkt_bytes[4] = plen[15:8];
    if (n > 5) pkt_bytes[5] = plen[7:0];
  endfunction

  // drive one item and wait for its acceptance
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic m,
                           input int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last      <= fin;
    byte_ch.mode      <= m;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  // mode rides on the first byte; later bytes carry random mode to be ignored
  task automatic send_packet(input logic m, input bit steady);
    foreach (pkt_bytes[i]) begin
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, (i == 0) ? m : logic'($urandom),
                steady ? 0 : pick_gap());
    end
    bytes_sent += pkt_bytes.size();
    packets_sent++;
  endtask

  // result receiver pacing
  initial begin : sink_pacing
    int unsigned run;
    logic        level;
    res_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        level = 1'b1;
        run   = $urandom_range(100, 300);
      end else begin
        level = logic'($urandom_range(0, 1));
        if (level) run = $urandom_range(1, 12);
        else       run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      end
      repeat (run) begin
        @(negedge clk_i);
        res_ch.ready <= level;
      end
    end
  end

  // monitor both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready)
        sb.take_byte(byte_ch.data_byte, byte_ch.last, byte_ch.mode);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.checksum, res_ch.short_packet);
    end
  end

  // watchdog on cycles without any accepted item
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) idle = 0;
      else idle++;
    end
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned r;
    int unsigned hl;
    int unsigned n;
    logic [3:0]  ihl;

    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.last      = 1'b0;
    byte_ch.mode      = 1'b0;
    bytes_sent        = 0;
    packets_sent      = 0;
    rst_ni            = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // plain checksum: single bytes at both extremes, all ones, odd length
    pkt_bytes = '{8'h00};                    send_packet(1'b0, 1'b0);
    pkt_bytes = '{8'hFF};                    send_packet(1'b0, 1'b0);
    pkt_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_packet(1'b0, 1'b1);
    fill_random(7);                          send_packet(1'b0, 1'b0);

    // ipv4: regular, longest header, odd payload
    make_v4(4'd5, 29, 16'd29);               send_packet(1'b1, 1'b0);
    make_v4(4'd15, 64, 16'd64);              send_packet(1'b1, 1'b1);
    // ihl below five: payload overlaps the address bytes
    make_v4(4'd0, 24, 16'd24);               send_packet(1'b1, 1'b0);
    make_v4(4'd2, 24, 16'd24);               send_packet(1'b1, 1'b0);
    make_v4(4'd4, 21, 16'd21);               send_packet(1'b1, 1'b0);
    // length underflow
    make_v4(4'd15, 61, 16'h0000);            send_packet(1'b1, 1'b0);
    make_v4(4'd5, 22, 16'hFFFF);             send_packet(1'b1, 1'b0);
    // short packets: inside the length word, before the addresses, short of ihl
    make_v4(4'd5, 1, 16'd0);                 send_packet(1'b1, 1'b0);
    make_v4(4'd5, 3, 16'd20);                send_packet(1'b1, 1'b0);
    make_v4(4'd5, 10, 16'd20);               send_packet(1'b1, 1'b0);
    make_v4(4'd5, 19, 16'd20);               send_packet(1'b1, 1'b0);
    make_v4(4'd15, 40, 16'd60);              send_packet(1'b1, 1'b0);

    // ipv6 and other versions taken as ipv6
    make_v6(4'd6, 45, 16'd5);                send_packet(1'b1, 1'b0);
    make_v6(4'd0, 45, 16'd5);                send_packet(1'b1, 1'b0);
    make_v6(4'd15, 41, 16'hFFFF);            send_packet(1'b1, 1'b0);
    make_v6(4'd6, 5, 16'd0);                 send_packet(1'b1, 1'b0);
    make_v6(4'd6, 39, 16'd0);                send_packet(1'b1, 1'b0);
    make_v6(4'd6, 40, 16'd0);                send_packet(1'b1, 1'b0);

    // random packets, mostly well formed
    while (bytes_sent < 900 || packets_sent < 40) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        fill_random($urandom_range(1, 16));
        send_packet(1'b0, $urandom_range(0, 3) == 0);
      end else if (r < 60) begin
        ihl = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(5, 7));
        hl  = 4 * int'(ihl);
        n   = hl + $urandom_range(0, 10);
        make_v4(ihl, n, 16'(n));
        send_packet($urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
      end else if (r < 85) begin
        n = 40 + $urandom_range(0, 8);
        make_v6(4'd6, n, 16'(n - 40));
        send_packet($urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0);
      end else if (r < 92) begin
        // truncated headers
        if ($urandom_range(0, 1)) make_v4(4'($urandom_range(5, 15)), $urandom_range(1, 19),
                                          16'($urandom));
        else make_v6(4'd6, $urandom_range(1, 39), 16'($urandom));
        send_packet(1'b1, 1'b0);
      end else begin
        // noise: any version, any ihl, any length field
        fill_random($urandom_range(1, 48));
        send_packet(logic'($urandom), 1'b0);
      end
    end

    @(negedge clk_i);
    byte_ch.valid <= 1'b0;

    // drain, then allow for a stray result
    while (sb.expected_sums.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
